// ===== hdl/bni_pkg.sv =====
// Package for the batch normalization inference pipeline.
// Holds register indexes and the sideband word type; no dependencies.
package bni_pkg;

    localparam int EPS_WIDTH = 24;
    localparam int VAR_WIDTH = 25;
    localparam int FIELD_WIDTH = 16;

    localparam logic REG_EPSILON = 1'b0;
    localparam logic REG_SCALE_ENABLE = 1'b1;

    typedef struct packed {
        logic                          valid;
        logic                          neg;
        logic                          big;
        logic                          zero;
        logic signed [FIELD_WIDTH-1:0] offset;
    } side_t;

endpackage

// ===== hdl/bni_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Uses bni_pkg for the divisor width.
module bni_div #(
    parameter int QW = 36
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [bni_pkg::VAR_WIDTH-1:0]  rem_in,
    input  logic [QW-1:0]                  low_in,
    input  logic [bni_pkg::VAR_WIDTH-1:0]  div_in,
    output logic [QW-1:0]                  quo_out
);

    localparam int VW = bni_pkg::VAR_WIDTH;

    logic [VW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [VW-1:0] div_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [VW-1:0] rem_p;
        logic [QW-1:0] low_p;
        logic [QW-1:0] quo_p;
        logic [VW-1:0] div_p;
        logic [VW:0]   trial;
        logic [VW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_p = rem_in;
            assign low_p = low_in;
            assign quo_p = '0;
            assign div_p = div_in;
        end
        else begin : g_rest
            assign rem_p = rem_reg[k-1];
            assign low_p = low_reg[k-1];
            assign quo_p = quo_reg[k-1];
            assign div_p = div_reg[k-1];
        end

        assign trial = {rem_p, low_p[QW-1]};
        assign ge    = trial >= {1'b0, div_p};
        assign diff  = trial - {1'b0, div_p};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
                low_reg[k] <= {low_p[QW-2:0], 1'b0};
                quo_reg[k] <= {quo_p[QW-2:0], ge};
                div_reg[k] <= div_p;
            end
        end
    end

    assign quo_out = quo_reg[QW-1];

endmodule

// ===== hdl/bni_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// No package dependencies.
module bni_sqrt #(
    parameter int RW = 18
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*RW-1:0] x_in,
    output logic [RW-1:0]   root_out
);

    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] x_reg    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   rem_p;
        logic [RW-1:0]   root_p;
        logic [2*RW-1:0] x_p;
        logic [RW+3:0]   cur;
        logic [RW+3:0]   trial;
        logic [RW+3:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign x_p    = x_in;
        end
        else begin : g_rest
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign x_p    = x_reg[k-1];
        end

        assign cur   = {rem_p, x_p[2*RW-1:2*RW-2]};
        assign trial = {2'b00, root_p, 2'b01};
        assign ge    = cur >= trial;
        assign diff  = cur - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? diff[RW+1:0] : cur[RW+1:0];
                root_reg[k] <= {root_p[RW-2:0], ge};
                x_reg[k]    <= {x_p[2*RW-3:0], 2'b00};
            end
        end
    end

    assign root_out = root_reg[RW-1];

endmodule

// ===== hdl/batch_norm_inference.sv =====
// Top level of the batch normalization inference pipeline.
// Uses bni_pkg, bni_div and bni_sqrt.
//
//   channel   direction   handshake             payload
//   in        input       in_valid / in_stall   sample, channel_* fields
//   out       output      out_valid / out_stall normalized, saturated
//   cfg       input       cfg_write             cfg_index, cfg_data
//
// One word enters per cycle while no stall holds it; the divider and square root
// units, one bit per stage, are sized from W, the wider of DATA_WIDTH and 16.
// Reset clears valid bits and sets config registers to 1; payload isn't reset.
// A stalled output holding a valid word freezes the pipeline and raises in_stall.
module batch_norm_inference #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [bni_pkg::FIELD_WIDTH-1:0] sample,
    input  logic signed [bni_pkg::FIELD_WIDTH-1:0] channel_mean,
    input  logic [bni_pkg::EPS_WIDTH-1:0]          channel_variance,
    input  logic signed [bni_pkg::FIELD_WIDTH-1:0] channel_scale,
    input  logic signed [bni_pkg::FIELD_WIDTH-1:0] channel_offset,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [bni_pkg::FIELD_WIDTH-1:0] normalized,
    output logic                                  saturated,
    input  logic                                  cfg_write,
    input  logic                                  cfg_index,
    input  logic [bni_pkg::EPS_WIDTH-1:0]          cfg_data
);

    localparam int FW = bni_pkg::FIELD_WIDTH;
    localparam int VW = bni_pkg::VAR_WIDTH;
    localparam int BW = (DATA_WIDTH > FW) ? DATA_WIDTH : FW;
    localparam int RW = BW + 2;
    localparam int QW = 2 * RW;
    localparam int L  = QW + RW;
    localparam int SW = BW + 3;
    localparam int EW = 66 + QW;
    localparam logic signed [SW-1:0] HI = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] LO = -HI - SW'(1);

    logic [bni_pkg::EPS_WIDTH-1:0] epsilon_reg;
    logic                          scale_enable_reg;
    logic                          en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg      <= bni_pkg::EPS_WIDTH'(1);
            scale_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                bni_pkg::REG_EPSILON:      epsilon_reg      <= cfg_data;
                bni_pkg::REG_SCALE_ENABLE: scale_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Stage 1: difference, scale select, variance sum.
    logic              v1_reg;
    logic signed [16:0] d1_reg;
    logic signed [16:0] g1_reg;
    logic [VW-1:0]     var1_reg;
    logic signed [FW-1:0] off1_reg;

    // Stage 2: product. Stage 3: magnitude. Stage 4: square. Stage 5: divide setup.
    logic              v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [31:0] n2_reg;
    logic [VW-1:0]     var2_reg, var3_reg, var4_reg, var5_reg;
    logic signed [FW-1:0] off2_reg, off3_reg, off4_reg;
    logic [31:0]       mag3_reg;
    logic              neg3_reg, neg4_reg;
    logic [63:0]       a4_reg;
    logic              zero4_reg;
    logic [VW-1:0]     rem5_reg;
    logic [QW-1:0]     low5_reg;
    bni_pkg::side_t    side5_reg;

    logic signed [33:0] prod2_next;
    logic [EW-1:0]      ext4;
    logic [EW-1:0]      top4;
    logic               big4;

    assign prod2_next = d1_reg * g1_reg;
    assign ext4       = {{QW{1'b0}}, a4_reg, 2'b00};
    assign top4       = ext4 >> QW;
    assign big4       = (top4 >= EW'(var4_reg)) && !zero4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg   <= 17'(sample) - 17'(channel_mean);
            g1_reg   <= scale_enable_reg ? 17'(channel_scale) : 17'sd256;
            var1_reg <= VW'(channel_variance) + VW'(epsilon_reg);
            off1_reg <= channel_offset;

            n2_reg   <= prod2_next[31:0];
            var2_reg <= var1_reg;
            off2_reg <= off1_reg;

            neg3_reg <= n2_reg[31];
            mag3_reg <= n2_reg[31] ? 32'(-n2_reg) : 32'(n2_reg);
            var3_reg <= var2_reg;
            off3_reg <= off2_reg;

            a4_reg    <= 64'(mag3_reg) * 64'(mag3_reg);
            zero4_reg <= mag3_reg == '0;
            neg4_reg  <= neg3_reg;
            var4_reg  <= var3_reg;
            off4_reg  <= off3_reg;

            rem5_reg         <= top4[VW-1:0];
            low5_reg         <= ext4[QW-1:0];
            var5_reg         <= var4_reg;
            side5_reg.valid  <= 1'b0;
            side5_reg.neg    <= neg4_reg;
            side5_reg.big    <= big4;
            side5_reg.zero   <= zero4_reg;
            side5_reg.offset <= off4_reg;
        end
    end

    logic [QW-1:0] quo;
    logic [RW-1:0] root;

    bni_div #(.QW(QW)) u_div (
        .clk     (clk),
        .en      (en),
        .rem_in  (rem5_reg),
        .low_in  (low5_reg),
        .div_in  (var5_reg),
        .quo_out (quo)
    );

    bni_sqrt #(.RW(RW)) u_sqrt (
        .clk      (clk),
        .en       (en),
        .x_in     (quo),
        .root_out (root)
    );

    // Sideband delay line matched to the divider and square root stages.
    bni_pkg::side_t side_reg [L];
    logic           vd_reg   [L];

    for (genvar k = 0; k < L; k++) begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vd_reg[k] <= (k == 0) ? v5_reg : vd_reg[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= (k == 0) ? side5_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    bni_pkg::side_t   side_f;
    logic [RW:0]      rinc;
    logic [RW-1:0]    q;
    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] y;
    logic signed [FW-1:0] normalized_next;
    logic             saturated_next;

    assign side_f = side_reg[L-1];
    assign rinc   = {1'b0, root} + (RW+1)'(1);
    assign q      = side_f.zero ? '0 : rinc[RW:1];
    assign qs     = SW'(q);
    assign y      = (side_f.neg ? -qs : qs) + SW'(side_f.offset);

    always_comb
    begin
        normalized_next = y[FW-1:0];
        saturated_next  = 1'b0;
        if (side_f.big)
        begin
            normalized_next = side_f.neg ? LO[FW-1:0] : HI[FW-1:0];
            saturated_next  = 1'b1;
        end
        else if (y > HI)
        begin
            normalized_next = HI[FW-1:0];
            saturated_next  = 1'b1;
        end
        else if (y < LO)
        begin
            normalized_next = LO[FW-1:0];
            saturated_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vd_reg[L-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            normalized <= normalized_next;
            saturated  <= saturated_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the batch normalization inference pipeline.
// Depends on bni_pkg and batch_norm_inference; predicts each word in exact integers.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic signed [15:0] smp;
        logic signed [15:0] mean;
        logic [23:0]        vari;
        logic signed [15:0] scl;
        logic signed [15:0] ofs;
    } bn_word_t;

    typedef struct {
        logic signed [15:0] norm;
        logic               sat;
    } bn_result_t;

    typedef struct {
        bn_word_t   w;
        logic       known;
        bn_result_t r;
    } bn_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] sample;
    logic signed [15:0] channel_mean;
    logic [23:0] channel_variance;
    logic signed [15:0] channel_scale;
    logic signed [15:0] channel_offset;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] normalized;
    logic saturated;
    logic cfg_write;
    logic cfg_index;
    logic [23:0] cfg_data;

    logic [23:0] eps_reg;
    logic        scale_en_reg;
    bn_result_t  pending_results[$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          sat_seen;
    bit          hold_long;

    batch_norm_inference #(.DATA_WIDTH(16)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .channel_mean(channel_mean),
        .channel_variance(channel_variance), .channel_scale(channel_scale),
        .channel_offset(channel_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .normalized(normalized), .saturated(saturated),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bn_result_t normalize_word(bn_word_t w);
        bn_result_t res;
        longint n;
        longint g;
        longint y;
        longint unsigned mag;
        longint unsigned v;
        longint unsigned q;
        longint unsigned a;
        longint unsigned odd;
        g = scale_en_reg ? longint'(w.scl) : 256;
        n = (longint'(w.smp) - longint'(w.mean)) * g;
        mag = (n < 0) ? -n : n;
        v = longint'(w.vari) + longint'(eps_reg);
        if (v == 0)
            q = (mag == 0) ? 0 : (64'd1 << 40);
        else
        begin
            a = mag * mag;
            q = int_sqrt(a / v);
            odd = 2 * q + 1;
            if (((4 * a) / v) / odd >= odd)
                q = q + 1;
        end
        y = (n < 0) ? -longint'(q) : longint'(q);
        y = y + longint'(w.ofs);
        res.sat = 1'b0;
        if (y > 32767)
        begin
            y = 32767;
            res.sat = 1'b1;
        end
        else if (y < -32768)
        begin
            y = -32768;
            res.sat = 1'b1;
        end
        res.norm = y[15:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s at result %0d: got %0d, expected %0d",
                 what, words_checked, got, want);
        error_count++;
    endtask

    task automatic write_register(logic idx, logic [23:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == bni_pkg::REG_EPSILON)
            eps_reg = value;
        else
            scale_en_reg = value[0];
    endtask

    task automatic drain_pipeline();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic send_word(bn_word_t w, logic known, bn_result_t r);
        bn_result_t res;
        res = normalize_word(w);
        if (known && (res.norm !== r.norm || res.sat !== r.sat))
            report_mismatch("table entry", res.norm, r.norm);
        in_valid <= 1'b1;
        sample <= w.smp;
        channel_mean <= w.mean;
        channel_variance <= w.vari;
        channel_scale <= w.scl;
        channel_offset <= w.ofs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(known ? r : res);
        words_sent++;
    endtask

    task automatic idle_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return;
        in_valid <= 1'b0;
        if (k < 95)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(10, 60)) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_field();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'h7fff;
        if (k == 1)
            return 16'h8000;
        if (k < 5)
            return 16'($signed($urandom_range(0, 1023)) - 512);
        return 16'($urandom);
    endfunction

    function automatic bn_word_t rand_word();
        bn_word_t w;
        int k;
        w.smp = rand_field();
        w.mean = ($urandom_range(0, 3) == 0) ? w.smp : rand_field();
        w.scl = rand_field();
        w.ofs = rand_field();
        k = $urandom_range(0, 9);
        if (k == 0)
            w.vari = 24'd0;
        else if (k == 1)
            w.vari = 24'hffffff;
        else if (k < 6)
            w.vari = 24'($urandom_range(0, 24'h3ffff));
        else
            w.vari = 24'($urandom);
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_long)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 25)
            out_stall <= 1'b1;
        else if ($urandom_range(0, 99) < 3)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        bn_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", normalized, 0);
            else
            begin
                want = pending_results.pop_front();
                if (normalized !== want.norm)
                    report_mismatch("normalized", normalized, want.norm);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
                if (want.sat)
                    sat_seen++;
            end
            words_checked++;
        end
    end

    initial
    begin
        int cyc;
        hold_long = 1'b0;
        wait (words_sent >= 150);
        hold_long = 1'b1;
        for (cyc = 0; cyc < 200; cyc++)
            @(posedge clk);
        hold_long = 1'b0;
    end

    bn_row_t directed_table[] = '{
        '{'{16'sd0, 16'sd0, 24'd0, 16'sd256, 16'sd0}, 1'b1, '{16'sd0, 1'b0}},
        '{'{16'sd256, 16'sd0, 24'd65535, 16'sd256, 16'sd0}, 1'b1, '{16'sd256, 1'b0}},
        '{'{16'sh7fff, 16'sh8000, 24'd0, 16'sh7fff, 16'sh7fff}, 1'b1,
          '{16'sh7fff, 1'b1}},
        '{'{16'sh8000, 16'sh7fff, 24'd0, 16'sh7fff, 16'sh8000}, 1'b1,
          '{16'sh8000, 1'b1}},
        '{'{16'sd5, 16'sd5, 24'hffffff, 16'sh8000, 16'sh1234}, 1'b1,
          '{16'sh1234, 1'b0}},
        '{'{16'sh8000, 16'sh8000, 24'hffffff, 16'sh7fff, 16'sh8000}, 1'b0,
          '{16'sd0, 1'b0}},
        '{'{16'sh7fff, 16'sh8000, 24'hffffff, 16'sh8000, 16'sd0}, 1'b0,
          '{16'sd0, 1'b0}},
        '{'{16'sd100, -16'sd100, 24'd1000, 16'sd300, -16'sd50}, 1'b0,
          '{16'sd0, 1'b0}},
        '{'{-16'sd3, 16'sd2, 24'd12345, 16'sd0, 16'sd77}, 1'b1, '{16'sd77, 1'b0}},
        '{'{16'sd1, 16'sd0, 24'd3, 16'sd1, 16'sd0}, 1'b0, '{16'sd0, 1'b0}}
    };

    bn_row_t zero_div_table[] = '{
        '{'{16'sd10, 16'sd3, 24'd0, 16'sd1, 16'sd0}, 1'b1, '{16'sh7fff, 1'b1}},
        '{'{-16'sd10, 16'sd3, 24'd0, 16'sd1, 16'sd0}, 1'b1, '{16'sh8000, 1'b1}},
        '{'{16'sd4, 16'sd4, 24'd0, 16'sd9, -16'sd9}, 1'b1, '{-16'sd9, 1'b0}},
        '{'{16'sd4, 16'sd0, 24'd0, 16'sd0, 16'sh7fff}, 1'b1, '{16'sh7fff, 1'b0}},
        '{'{16'sd4, 16'sd0, 24'd1, 16'sd256, 16'sd0}, 1'b0, '{16'sd0, 1'b0}}
    };

    initial
    begin
        int i;
        int phase;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_write = 1'b0;
        cfg_index = bni_pkg::REG_EPSILON;
        cfg_data = '0;
        sample = '0;
        channel_mean = '0;
        channel_variance = '0;
        channel_scale = '0;
        channel_offset = '0;
        eps_reg = 24'd1;
        scale_en_reg = 1'b1;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        sat_seen = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_word(directed_table[i].w, directed_table[i].known,
                      directed_table[i].r);
        in_valid <= 1'b0;
        drain_pipeline();
        write_register(bni_pkg::REG_EPSILON, 24'd0);
        foreach (zero_div_table[i])
            send_word(zero_div_table[i].w, zero_div_table[i].known,
                      zero_div_table[i].r);
        in_valid <= 1'b0;
        drain_pipeline();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin write_register(bni_pkg::REG_EPSILON, 24'd1);
                         write_register(bni_pkg::REG_SCALE_ENABLE, 24'd0); end
                1: begin write_register(bni_pkg::REG_EPSILON, 24'hffffff);
                         write_register(bni_pkg::REG_SCALE_ENABLE, 24'd1); end
                2: write_register(bni_pkg::REG_EPSILON,
                                  24'($urandom_range(1, 24'h20000)));
                default: write_register(bni_pkg::REG_EPSILON, 24'd0);
            endcase
            for (i = 0; i < 100; i++)
            begin
                send_word(rand_word(), 1'b0, '{16'sd0, 1'b0});
                if (phase != 1 || i > 60)
                    idle_gap();
            end
            in_valid <= 1'b0;
            drain_pipeline();
        end
        $display("Sent %0d words over six register settings, checked %0d results,",
                 words_sent, words_checked);
        $display("%0d of them saturated, with one long output hold-off.", sat_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
